>>> rtl/itoa_pkg.sv
// itoa_pkg: shared widths, character codes and the digit lookup for the
// integer-to-ascii converter. No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

  // fixed payload widths
  localparam int NUMBER_W = 32;
  localparam int KIND_W   = 1;
  localparam int RADIX_W  = 5;
  localparam int CHAR_W   = 7;
  localparam int DIGIT_W  = 4;

  // radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;

  // conversion kind codes
  localparam logic [KIND_W-1:0] KIND_UNSIGNED = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SIGNED   = 1'b1;

  // digit value to lower-case ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOW_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> rtl/itoa_if.sv
// itoa_in_if / itoa_out_if: valid/ready channels for the request and the
// character stream. Depends on itoa_pkg for the payload widths.
`timescale 1ns / 1ps

interface itoa_in_if;
  logic                            valid;
  logic                            ready;
  logic [itoa_pkg::NUMBER_W-1:0]   number;
  logic [itoa_pkg::KIND_W-1:0]     kind;
  logic [itoa_pkg::RADIX_W-1:0]    radix;

  modport source (output valid, output number, output kind, output radix, input ready);
  modport sink   (input valid, input number, input kind, input radix, output ready);
endinterface

interface itoa_out_if;
  logic                            valid;
  logic                            ready;
  logic [itoa_pkg::CHAR_W-1:0]     character;
  logic                            last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/integer_to_ascii_radix.sv
// integer_to_ascii_radix: converts one word per request into ascii digits.
// Depends on itoa_pkg and the channel interfaces in itoa_if.sv.
`timescale 1ns / 1ps

// Takes a request (number, kind, radix) and emits its text one character
// per output transfer, most significant digit first, with last set on the
// final character; a signed negative value gets a leading '-'. Radix below
// 2 acts as 2 and above 16 as 16. A single nibble divider is reused for
// every digit: it consumes four bits of the word per cycle, walking every
// nibble of the word for each digit. The input is not ready from acceptance
// until the last character is loaded into the output register; the next
// request is taken while that character waits.
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  itoa_in_if.sink     in_ch,
  itoa_out_if.source  out_ch
);

  localparam int NIB    = (VALUE_WIDTH + 3) / 4;
  localparam int PAD_W  = NIB * 4;
  localparam int NIB_CW = $clog2(NIB);
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int EXT_W  = itoa_pkg::NUMBER_W + VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                              state_r;
  logic [PAD_W-1:0]                    work_r;
  logic [itoa_pkg::DIGIT_W-1:0]        rem_r;
  logic [itoa_pkg::RADIX_W-1:0]        radix_r;
  logic [NIB_CW-1:0]                   nib_cnt_r;
  logic [CNT_W-1:0]                    dig_cnt_r;
  logic                                neg_r;
  logic [itoa_pkg::DIGIT_W-1:0]        stack_r [VALUE_WIDTH];
  logic                                out_valid_r;
  logic [itoa_pkg::CHAR_W-1:0]         out_char_r;
  logic                                out_last_r;

  logic [EXT_W-1:0]                    num_ext;
  logic [VALUE_WIDTH-1:0]              word_in;
  logic [VALUE_WIDTH-1:0]              mag_in;
  logic                                neg_in;
  logic [itoa_pkg::RADIX_W-1:0]        radix_in;
  logic [PAD_W-1:0]                    work_nxt;
  logic [itoa_pkg::DIGIT_W-1:0]        rem_nxt;
  logic                                out_free;
  logic                                push;
  logic                                pop;

  // request decode: width fit, sign, radix clamp
  always_comb begin
    num_ext = {{VALUE_WIDTH{1'b0}}, in_ch.number};
    word_in = num_ext[VALUE_WIDTH-1:0];
    neg_in  = (in_ch.kind == itoa_pkg::KIND_SIGNED) && word_in[VALUE_WIDTH-1];
    mag_in  = neg_in ? (~word_in + VALUE_WIDTH'(1)) : word_in;
    if (in_ch.radix < itoa_pkg::RADIX_MIN) begin
      radix_in = itoa_pkg::RADIX_MIN;
    end else if (in_ch.radix > itoa_pkg::RADIX_MAX) begin
      radix_in = itoa_pkg::RADIX_MAX;
    end else begin
      radix_in = in_ch.radix;
    end
  end

  // shared divider step: {rem, top nibble} / radix, four restoring stages
  always_comb begin
    logic [8:0]                   t;
    logic [8:0]                   d;
    logic [itoa_pkg::DIGIT_W-1:0] q;
    t = {1'b0, rem_r, work_r[PAD_W-1 -: 4]};
    q = '0;
    for (int b = 3; b >= 0; b--) begin
      d = 9'(radix_r) << b;
      if (t >= d) begin
        t    = t - d;
        q[b] = 1'b1;
      end
    end
    rem_nxt  = t[3:0];
    work_nxt = {work_r[PAD_W-5:0], q};
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign push     = (state_r == S_DIV) && (nib_cnt_r == NIB_CW'(NIB - 1));
  assign pop      = (state_r == S_EMIT) && out_free && !neg_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (push && (work_nxt == '0)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pop && (dig_cnt_r == CNT_W'(1))) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      work_r    <= PAD_W'(mag_in);
      rem_r     <= '0;
      radix_r   <= radix_in;
      nib_cnt_r <= '0;
      dig_cnt_r <= '0;
      neg_r     <= neg_in;
    end else if (state_r == S_DIV) begin
      work_r <= work_nxt;
      if (push) begin
        rem_r     <= '0;
        nib_cnt_r <= '0;
        dig_cnt_r <= dig_cnt_r + CNT_W'(1);
      end else begin
        rem_r     <= rem_nxt;
        nib_cnt_r <= nib_cnt_r + NIB_CW'(1);
      end
    end else if (state_r == S_EMIT && out_free) begin
      if (neg_r) begin
        neg_r <= 1'b0;
      end else begin
        dig_cnt_r <= dig_cnt_r - CNT_W'(1);
      end
    end
  end

  // digit stack: push on the least significant digit, pop most significant
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[0] <= rem_nxt;
      for (int i = 1; i < VALUE_WIDTH; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      if (neg_r) begin
        out_char_r <= itoa_pkg::CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= itoa_pkg::digit_char(stack_r[0]);
        out_last_r <= (dig_cnt_r == CNT_W'(1));
      end
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // checks
  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, rem_r} < radix_r))
    else $error("divider remainder not below radix");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (dig_cnt_r != '0))
    else $error("emitting with an empty digit stack");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (dig_cnt_r <= CNT_W'(VALUE_WIDTH)))
    else $error("digit count beyond word width");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && dig_cnt_r == CNT_W'(1)) |=> (out_ch.valid && out_ch.last))
    else $error("final character not flagged last");

endmodule

>>> tb/tb.sv
// tb: self-checking bench for integer_to_ascii_radix, with random flow control on both channels.
// Depends on itoa_pkg, the channel interfaces in itoa_if.sv and the converter rtl.
`timescale 1ns / 1ps

module tb;

  localparam int VALUE_WIDTH    = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASE_REQUESTS = 115;

  // expected text per request, checked one character at a time
  class itoa_scoreboard;
    typedef struct packed {
      logic [itoa_pkg::CHAR_W-1:0] character;
      logic                        last;
    } text_char_t;

    text_char_t expected_chars[$];
    string      digit_set = "0123456789abcdef";
    int         errors;
    int         requests;
    int         chars_checked;

    // build the text of one request, sign first, most significant digit next
    function void note_request(input logic [itoa_pkg::NUMBER_W-1:0] number,
                               input logic [itoa_pkg::KIND_W-1:0] kind,
                               input logic [itoa_pkg::RADIX_W-1:0] radix);
      logic [VALUE_WIDTH-1:0]       magnitude;
      int unsigned                  base;
      logic [itoa_pkg::DIGIT_W-1:0] digits[$];
      text_char_t                   entry;
      byte                          code;
      magnitude = number[VALUE_WIDTH-1:0];
      base = 32'(radix);
      if (base < itoa_pkg::RADIX_MIN) base = 32'(itoa_pkg::RADIX_MIN);
      if (base > itoa_pkg::RADIX_MAX) base = 32'(itoa_pkg::RADIX_MAX);
      requests++;
      // negative signed word: minus sign, then the magnitude
      if (kind == itoa_pkg::KIND_SIGNED && magnitude[VALUE_WIDTH-1]) begin
        magnitude = -magnitude;
        entry.character = itoa_pkg::CHAR_MINUS;
        entry.last = 1'b0;
        expected_chars.push_back(entry);
      end
      do begin
        digits.push_front(itoa_pkg::DIGIT_W'(magnitude % base));
        magnitude = magnitude / base;
      end while (magnitude != 0);
      foreach (digits[i]) begin
        code = digit_set[digits[i]];
        entry.character = code[itoa_pkg::CHAR_W-1:0];
        entry.last = (i == digits.size() - 1);
        expected_chars.push_back(entry);
      end
    endfunction

    function void check_char(input logic [itoa_pkg::CHAR_W-1:0] character, input logic last);
      text_char_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character %h last %0b, nothing pending",
                 $time, character, last);
        return;
      end
      want = expected_chars.pop_front();
      if (character !== want.character) begin
        errors++;
        $display("%0t: character mismatch: expected %h, actual %h",
                 $time, want.character, character);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last flag mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  itoa_in_if  in_ch();
  itoa_out_if out_ch();

  itoa_scoreboard sb = new();

  int in_idle_pct;
  int out_stall_pct;
  int idle_cycles;

  integer_to_ascii_radix #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // monitor both channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.number, in_ch.kind, in_ch.radix);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_char(out_ch.character, out_ch.last);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles, %0d characters pending",
               $time, idle_cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request, after a random number of idle cycles
  task automatic send_request(input logic [itoa_pkg::NUMBER_W-1:0] number,
                              input logic [itoa_pkg::KIND_W-1:0] kind,
                              input logic [itoa_pkg::RADIX_W-1:0] radix);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= number;
    in_ch.kind   <= kind;
    in_ch.radix  <= radix;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // mix of full-range, small, power-of-two and near-extreme words
  function automatic logic [itoa_pkg::NUMBER_W-1:0] rand_number();
    logic [itoa_pkg::NUMBER_W-1:0] n;
    case ($urandom_range(5))
      0: n = $urandom;
      1: n = $urandom_range(0, 20);
      2: n = 32'h1 << $urandom_range(31);
      3: n = (32'h1 << $urandom_range(31)) - 32'h1;
      4: n = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(0, 8)
                               : 32'h7fff_ffff - $urandom_range(0, 8);
      default: n = $urandom >> $urandom_range(31);
    endcase
    return $urandom_range(7) == 0 ? ~n : n;
  endfunction

  // mostly legal radix, sometimes anything the field holds
  function automatic logic [itoa_pkg::RADIX_W-1:0] rand_radix();
    if ($urandom_range(9) == 0) return itoa_pkg::RADIX_W'($urandom_range(31));
    return itoa_pkg::RADIX_W'($urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX));
  endfunction

  task automatic send_random(input int count);
    repeat (count) begin
      send_request(rand_number(), itoa_pkg::KIND_W'($urandom_range(1)), rand_radix());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.number  = '0;
    in_ch.kind    = itoa_pkg::KIND_UNSIGNED;
    in_ch.radix   = itoa_pkg::RADIX_MIN;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, extremes, most negative value, radix clamping
    send_request(32'h0000_0000, itoa_pkg::KIND_UNSIGNED, 5'd10);
    send_request(32'h0000_0000, itoa_pkg::KIND_SIGNED,   itoa_pkg::RADIX_MIN);
    send_request(32'hffff_ffff, itoa_pkg::KIND_UNSIGNED, itoa_pkg::RADIX_MIN);
    send_request(32'hffff_ffff, itoa_pkg::KIND_SIGNED,   5'd10);
    send_request(32'hffff_ffff, itoa_pkg::KIND_UNSIGNED, itoa_pkg::RADIX_MAX);
    send_request(32'h8000_0000, itoa_pkg::KIND_SIGNED,   itoa_pkg::RADIX_MIN);
    send_request(32'h8000_0000, itoa_pkg::KIND_SIGNED,   5'd10);
    send_request(32'h8000_0000, itoa_pkg::KIND_UNSIGNED, itoa_pkg::RADIX_MAX);
    send_request(32'h7fff_ffff, itoa_pkg::KIND_SIGNED,   5'd10);
    send_request(32'h7fff_ffff, itoa_pkg::KIND_UNSIGNED, 5'd3);
    send_request(32'h0000_0001, itoa_pkg::KIND_SIGNED,   5'd7);
    send_request(32'hdead_beef, itoa_pkg::KIND_UNSIGNED, itoa_pkg::RADIX_MAX);
    send_request(32'hdead_beef, itoa_pkg::KIND_SIGNED,   5'd8);
    send_request(32'h0000_00ff, itoa_pkg::KIND_UNSIGNED, 5'd0);
    send_request(32'h0000_00ff, itoa_pkg::KIND_SIGNED,   5'd1);
    send_request(32'h0000_00ff, itoa_pkg::KIND_UNSIGNED, 5'd17);
    send_request(32'hffff_ff01, itoa_pkg::KIND_SIGNED,   5'd31);
    send_request(32'h0012_d687, itoa_pkg::KIND_UNSIGNED, 5'd10);
    send_request(32'h0000_0024, itoa_pkg::KIND_UNSIGNED, 5'd6);
    send_request(32'hfedc_ba98, itoa_pkg::KIND_SIGNED,   5'd12);

    // random traffic: no idling, idle sender, stalling receiver, both
    send_random(PHASE_REQUESTS);
    in_idle_pct = 45;
    send_random(PHASE_REQUESTS);
    in_idle_pct   = 0;
    out_stall_pct = 45;
    send_random(PHASE_REQUESTS);
    in_idle_pct   = 29;
    out_stall_pct = 29;
    send_random(PHASE_REQUESTS);
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // drain, then watch for stray characters
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d characters over four flow-control phases",
             sb.requests, sb.chars_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
